[rtl/segment_sphere_intersection_defines.svh]
// ----------------------------------------------------------------------------
// segment_sphere_intersection assertion macros
// Concurrent check helpers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_SPHERE_INTERSECTION_DEFINES_SVH
`define SEGMENT_SPHERE_INTERSECTION_DEFINES_SVH

`ifndef SYNTH
`define SSI_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("segment_sphere_intersection: check failed");
`define SSI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("segment_sphere_intersection: check failed");
`else
`define SSI_ASSERT(label, cond)
`define SSI_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[rtl/ssi_pkg.sv]
// ----------------------------------------------------------------------------
// ssi_pkg
// Widths, status codes and stage payload types of the intersection pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package ssi_pkg;

  localparam logic [1:0] ST_TWO     = 2'd0;
  localparam logic [1:0] ST_TANGENT = 2'd1;
  localparam logic [1:0] ST_ZERO    = 2'd2;
  localparam logic [1:0] ST_BADIDX  = 2'd3;

  localparam int SQ_STEPS = 67;            // root bits
  localparam int DW       = 2 * SQ_STEPS;  // discriminant width
  localparam int RW       = 69;            // root remainder width
  localparam int QB       = 41;            // quotient bits

  typedef struct packed {
    logic [2:0][31:0] p;
    logic [2:0][32:0] w;
    logic             ent;
    logic             idx;
  } base_t;

  typedef struct packed {
    logic [2:0][31:0] p;
    logic [2:0][31:0] wm;
    logic [2:0]       wneg;
    logic [66:0]      h;
    logic [65:0]      a;
    logic [1:0]       status;
    logic             sneg;
  } sq_pl_t;

  typedef struct packed {
    logic [2:0][31:0] p;
    logic [2:0]       neg;
    logic [2:0]       ovf;
    logic [66:0]      d2;
    logic [1:0]       status;
  } dv_pl_t;

  typedef struct packed {
    logic [2:0][66:0]   rem;
    logic [2:0][QB-1:0] nlo;
    logic [2:0][QB-1:0] q;
  } dv_t;

endpackage

`default_nettype wire

[rtl/segment_sphere_intersection.sv]
// ----------------------------------------------------------------------------
// segment_sphere_intersection
// Throughput: one item per cycle; the whole pipeline holds while a result waits.
// The 67-step square root and 41-step divider set the depth.
// Reset clears the stage valid bits only; data registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none
`include "segment_sphere_intersection_defines.svh"

module segment_sphere_intersection (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] first_x,
  input  logic signed [31:0] first_y,
  input  logic signed [31:0] first_z,
  input  logic signed [31:0] second_x,
  input  logic signed [31:0] second_y,
  input  logic signed [31:0] second_z,
  input  logic signed [31:0] center_x,
  input  logic signed [31:0] center_y,
  input  logic signed [31:0] center_z,
  input  logic        [30:0] radius,
  input  logic               enters_first,
  input  logic               crossing_index,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] point_x,
  output logic signed [31:0] point_y,
  output logic signed [31:0] point_z,
  output logic        [1:0]  status
);
  import ssi_pkg::*;

  localparam int SQ0_V = 5;
  localparam int SQE_V = SQ0_V + SQ_STEPS;
  localparam int NSTG  = SQE_V + 3 + QB + 2;

  logic [NSTG-1:0] vld;
  logic            adv;

  assign adv       = !vld[NSTG-1] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NSTG-2:0], in_valid};
    end
  end

  // S1: offsets
  logic [2:0][31:0] in_p, in_q, in_c;
  assign in_p = {first_z, first_y, first_x};
  assign in_q = {second_z, second_y, second_x};
  assign in_c = {center_z, center_y, center_x};

  logic [2:0][32:0] s1_u;
  base_t            s1_b;
  logic [30:0]      s1_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s1_u[i]   <= 33'($signed(in_p[i])) - 33'($signed(in_c[i]));
        s1_b.w[i] <= 33'($signed(in_q[i])) - 33'($signed(in_p[i]));
      end
      s1_b.p   <= in_p;
      s1_b.ent <= enters_first;
      s1_b.idx <= crossing_index;
      s1_r     <= radius;
    end
  end

  // S2: products
  logic signed [65:0] m_ww [3];
  logic signed [65:0] m_uw [3];
  logic signed [65:0] m_uu [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m_ww[i] = 66'($signed(s1_b.w[i])) * 66'($signed(s1_b.w[i]));
      m_uw[i] = 66'($signed(s1_u[i])) * 66'($signed(s1_b.w[i]));
      m_uu[i] = 66'($signed(s1_u[i])) * 66'($signed(s1_u[i]));
    end
  end

  logic [2:0][63:0] s2_ww, s2_uu;
  logic [2:0][64:0] s2_uw;
  logic [61:0]      s2_rr;
  base_t            s2_b;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s2_ww[i] <= m_ww[i][63:0];
        s2_uw[i] <= m_uw[i][64:0];
        s2_uu[i] <= m_uu[i][63:0];
      end
      s2_rr <= 62'(s1_r) * 62'(s1_r);
      s2_b  <= s1_b;
    end
  end

  // S3: a, h, c
  logic [65:0] s3_a;
  logic [66:0] s3_h, s3_c;
  base_t       s3_b;

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_a <= 66'(s2_ww[0]) + 66'(s2_ww[1]) + 66'(s2_ww[2]);
      s3_h <= 67'($signed(s2_uw[0])) + 67'($signed(s2_uw[1])) + 67'($signed(s2_uw[2]));
      s3_c <= 67'(s2_uu[0]) + 67'(s2_uu[1]) + 67'(s2_uu[2]) - 67'(s2_rr);
      s3_b <= s2_b;
    end
  end

  // S4: partial products of h*h and a*|c|
  logic [66:0] h_neg, c_neg;
  logic [65:0] hm, cm;

  always_comb begin
    h_neg = -s3_h;
    c_neg = -s3_c;
    hm    = s3_h[66] ? h_neg[65:0] : s3_h[65:0];
    cm    = s3_c[66] ? c_neg[65:0] : s3_c[65:0];
  end

  logic [65:0] s4_hh00, s4_hh01, s4_hh11;
  logic [65:0] s4_ac00, s4_ac01, s4_ac10, s4_ac11;
  logic        s4_cneg;
  logic [65:0] s4_a;
  logic [66:0] s4_h;
  base_t       s4_b;

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_hh00 <= 66'(hm[32:0]) * 66'(hm[32:0]);
      s4_hh01 <= 66'(hm[32:0]) * 66'(hm[65:33]);
      s4_hh11 <= 66'(hm[65:33]) * 66'(hm[65:33]);
      s4_ac00 <= 66'(s3_a[32:0]) * 66'(cm[32:0]);
      s4_ac01 <= 66'(s3_a[32:0]) * 66'(cm[65:33]);
      s4_ac10 <= 66'(s3_a[65:33]) * 66'(cm[32:0]);
      s4_ac11 <= 66'(s3_a[65:33]) * 66'(cm[65:33]);
      s4_cneg <= s3_c[66];
      s4_a    <= s3_a;
      s4_h    <= s3_h;
      s4_b    <= s3_b;
    end
  end

  // S5: h*h and a*|c|
  logic [131:0] s5_hh, s5_ac;
  logic         s5_cneg;
  logic [65:0]  s5_a;
  logic [66:0]  s5_h;
  base_t        s5_b;

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_hh   <= 132'(s4_hh00) + (132'(s4_hh01) << 34) + (132'(s4_hh11) << 66);
      s5_ac   <= 132'(s4_ac00) + ((132'(s4_ac01) + 132'(s4_ac10)) << 33)
               + (132'(s4_ac11) << 66);
      s5_cneg <= s4_cneg;
      s5_a    <= s4_a;
      s5_h    <= s4_h;
      s5_b    <= s4_b;
    end
  end

  // S6: discriminant and status
  logic [DW-1:0]    sq_d    [SQ_STEPS+1];
  logic [RW-1:0]    sq_rem  [SQ_STEPS+1];
  logic [SQ_STEPS-1:0] sq_root [SQ_STEPS+1];
  sq_pl_t           sq_pl   [SQ_STEPS+1];

  logic [DW-1:0] dd;
  logic          dpos;
  logic [1:0]    st6;
  sq_pl_t        pl6;
  logic [32:0]   wn6;

  always_comb begin
    dd   = s5_cneg ? (DW'(s5_hh) + DW'(s5_ac)) : (DW'(s5_hh) - DW'(s5_ac));
    dpos = !dd[DW-1] && (dd != '0);
    if (s5_a == '0) begin
      st6 = ST_ZERO;
    end else if (dpos) begin
      st6 = (!s5_b.ent && s5_b.idx) ? ST_BADIDX : ST_TWO;
    end else begin
      st6 = ST_TANGENT;
    end
    pl6.p      = s5_b.p;
    pl6.h      = s5_h;
    pl6.a      = s5_a;
    pl6.status = st6;
    pl6.sneg   = dpos && s5_b.ent && !s5_b.idx;
    wn6        = '0;
    for (int i = 0; i < 3; i++) begin
      wn6         = -s5_b.w[i];
      pl6.wneg[i] = s5_b.w[i][32];
      pl6.wm[i]   = s5_b.w[i][32] ? wn6[31:0] : s5_b.w[i][31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_d[0]    <= dpos ? dd : '0;
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
      sq_pl[0]   <= pl6;
    end
  end

  // square root, one bit per stage
  for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sqrt
    logic [RW+1:0] rem_t, trial;
    logic          ge;

    assign rem_t = {sq_rem[g], sq_d[g][DW-1 -: 2]};
    assign trial = (RW+2)'({sq_root[g], 2'b01});
    assign ge    = rem_t >= trial;

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_rem[g+1]  <= ge ? RW'(rem_t - trial) : RW'(rem_t);
        sq_root[g+1] <= {sq_root[g][SQ_STEPS-2:0], ge};
        sq_d[g+1]    <= sq_d[g] << 2;
        sq_pl[g+1]   <= sq_pl[g];
      end
    end
  end

  // S7: n = -h +- s
  sq_pl_t      pl_e;
  logic [68:0] nv, nvn;

  always_comb begin
    pl_e = sq_pl[SQ_STEPS];
    nv   = pl_e.sneg ? (-69'($signed(pl_e.h)) - 69'(sq_root[SQ_STEPS]))
                     : (-69'($signed(pl_e.h)) + 69'(sq_root[SQ_STEPS]));
    nvn  = -nv;
  end

  logic [67:0] s7_nm;
  logic        s7_nneg;
  sq_pl_t      s7_pl;

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_nm   <= nv[68] ? nvn[67:0] : nv[67:0];
      s7_nneg <= nv[68];
      s7_pl   <= pl_e;
    end
  end

  // S8: |w| * |n| partials
  logic [2:0][65:0] s8_pp0, s8_pp1;
  logic [2:0]       s8_neg;
  sq_pl_t           s8_pl;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s8_pp0[i] <= 66'(s7_pl.wm[i]) * 66'(s7_nm[33:0]);
        s8_pp1[i] <= 66'(s7_pl.wm[i]) * 66'(s7_nm[67:34]);
        s8_neg[i] <= s7_pl.wneg[i] ^ s7_nneg;
      end
      s8_pl <= s7_pl;
    end
  end

  // S9: rounded numerator and range check
  dv_t    dv  [QB+1];
  dv_pl_t dvp [QB+1];

  logic [99:0]  prod9 [3];
  logic [101:0] nn9   [3];
  logic [66:0]  d2_9;
  dv_t          dv9;
  logic [2:0]   ovf9;

  always_comb begin
    d2_9 = {s8_pl.a, 1'b0};
    dv9  = '0;
    ovf9 = '0;
    for (int i = 0; i < 3; i++) begin
      prod9[i]   = 100'(s8_pp0[i]) + (100'(s8_pp1[i]) << 34);
      nn9[i]     = 102'({prod9[i], 1'b0}) + 102'(s8_pl.a);
      ovf9[i]    = {6'b0, nn9[i]} >= {d2_9, 41'b0};
      dv9.rem[i] = 67'(nn9[i][101:QB]);
      dv9.nlo[i] = nn9[i][QB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv[0]         <= dv9;
      dvp[0].p      <= s8_pl.p;
      dvp[0].neg    <= s8_neg;
      dvp[0].ovf    <= ovf9;
      dvp[0].d2     <= d2_9;
      dvp[0].status <= s8_pl.status;
    end
  end

  // division, one quotient bit per stage
  for (genvar g = 0; g < QB; g++) begin : g_div
    dv_t dn;

    always_comb begin
      logic [67:0] rt;
      logic        ge;
      rt = '0;
      ge = 1'b0;
      dn = dv[g];
      for (int i = 0; i < 3; i++) begin
        rt         = {dv[g].rem[i], dv[g].nlo[i][QB-1]};
        ge         = rt >= {1'b0, dvp[g].d2};
        dn.rem[i]  = ge ? 67'(rt - {1'b0, dvp[g].d2}) : rt[66:0];
        dn.q[i]    = {dv[g].q[i][QB-2:0], ge};
        dn.nlo[i]  = dv[g].nlo[i] << 1;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv[g+1]  <= dn;
        dvp[g+1] <= dvp[g];
      end
    end
  end

  // output stage
  logic [2:0][31:0] res;
  logic [41:0]      t;
  logic             huge;
  dv_pl_t           pe;

  always_comb begin
    pe   = dvp[QB];
    t    = '0;
    huge = 1'b0;
    for (int i = 0; i < 3; i++) begin
      huge = pe.ovf[i] | dv[QB].q[i][QB-1];
      t    = pe.neg[i] ? (42'($signed(pe.p[i])) - 42'(dv[QB].q[i][QB-2:0]))
                       : (42'($signed(pe.p[i])) + 42'(dv[QB].q[i][QB-2:0]));
      if (huge) begin
        res[i] = pe.neg[i] ? 32'h8000_0000 : 32'h7fff_ffff;
      end else if (t[41:31] != {11{t[41]}}) begin
        res[i] = t[41] ? 32'h8000_0000 : 32'h7fff_ffff;
      end else begin
        res[i] = t[31:0];
      end
      case (pe.status)
        ST_ZERO:   res[i] = pe.p[i];
        ST_BADIDX: res[i] = '0;
        default:   ;
      endcase
    end
  end

  logic [2:0][31:0] o_p;
  logic [1:0]       o_st;

  always_ff @(posedge clk) begin
    if (adv) begin
      o_p  <= res;
      o_st <= pe.status;
    end
  end

  assign point_x = o_p[0];
  assign point_y = o_p[1];
  assign point_z = o_p[2];
  assign status  = o_st;

  `SSI_ASSERT_NEXT(a_stall_hold, !adv, vld == $past(vld))
  `SSI_ASSERT(a_badidx_zero, !(out_valid && status == ST_BADIDX) || (o_p == '0))
  `SSI_ASSERT(a_two_root, !(vld[SQE_V] && sq_pl[SQ_STEPS].status == ST_TWO) || (sq_root[SQ_STEPS] != '0))
  `SSI_ASSERT(a_zero_len, !(vld[SQ0_V] && sq_pl[0].status == ST_ZERO) || (sq_pl[0].a == '0))

endmodule

`default_nettype wire

[dv/segment_sphere_intersection_tb.sv]
// ----------------------------------------------------------------------------
// segment_sphere_intersection_tb
// Drives segment/sphere queries through valid/ready with random gaps on both
// sides, predicts each intersection point with exact wide arithmetic and
// checks every output transfer in order. A directed table comes first,
// then mostly well-formed random crossings mixed with raw random items.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_sphere_intersection_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ssi_pkg::*;

  localparam int  N_RAND   = 1200;
  localparam int  N_DIR    = 14;
  localparam int  LIMIT    = 400000;
  localparam int  LATENCY  = 118;
  localparam int  ONE      = 65536;

  typedef struct packed {
    logic [2:0][31:0] p;
    logic [2:0][31:0] q;
    logic [2:0][31:0] ctr;
    logic [30:0]      r;
    logic             ent;
    logic             idx;
  } query_t;

  typedef struct packed {
    logic [2:0][31:0] pt;
    logic [1:0]       st;
  } hit_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic out_ready = 1'b0;
  logic in_ready, out_valid;
  logic signed [31:0] first_x = '0, first_y = '0, first_z = '0;
  logic signed [31:0] second_x = '0, second_y = '0, second_z = '0;
  logic signed [31:0] center_x = '0, center_y = '0, center_z = '0;
  logic [30:0] radius = '0;
  logic enters_first = 1'b0, crossing_index = 1'b0;
  logic signed [31:0] point_x, point_y, point_z;
  logic [1:0] status;

  hit_t hits_pending[$];
  int   errors = 0;
  int   cycles = 0;
  int   n_sent = 0;

  always #5 clk = ~clk;

  segment_sphere_intersection u_dut (
    .clk, .rst, .in_valid, .in_ready,
    .first_x, .first_y, .first_z, .second_x, .second_y, .second_z,
    .center_x, .center_y, .center_z, .radius, .enters_first,
    .crossing_index, .out_valid, .out_ready, .point_x, .point_y, .point_z, .status
  );

  function automatic logic [191:0] isqrt(logic [191:0] n);
    logic [191:0] res, cand;
    res = '0;
    for (int b = 95; b >= 0; b--) begin
      cand = res | (192'd1 << b);
      if (cand * cand <= n) res = cand;
    end
    return res;
  endfunction

  function automatic hit_t predict_hit(query_t it);
    logic signed [191:0] pi[3], u[3], w[3], a, h, c, d, s, n, nm, wm, prod, q, res;
    logic neg;
    hit_t o;
    a = '0; h = '0; c = '0;
    for (int i = 0; i < 3; i++) begin
      pi[i] = $signed(it.p[i]);
      u[i]  = pi[i] - $signed(it.ctr[i]);
      w[i]  = $signed(it.q[i]) - pi[i];
      a += w[i] * w[i];
      h += u[i] * w[i];
      c += u[i] * u[i];
    end
    if (a == 0) begin
      o.pt = it.p;
      o.st = ST_ZERO;
      return o;
    end
    c = c - $signed({161'd0, it.r}) * $signed({161'd0, it.r});
    d = h * h - a * c;
    if (d > 0) begin
      if (!it.ent && it.idx) begin
        o.pt = '0;
        o.st = ST_BADIDX;
        return o;
      end
      s = $signed(isqrt(d));
      if (it.ent && !it.idx) s = -s;
      o.st = ST_TWO;
    end else begin
      s = '0;
      o.st = ST_TANGENT;
    end
    n  = -h + s;
    nm = (n < 0) ? -n : n;
    for (int i = 0; i < 3; i++) begin
      wm   = (w[i] < 0) ? -w[i] : w[i];
      neg  = (w[i] < 0) != (n < 0);
      prod = wm * nm;
      q    = (2 * prod + a) / (2 * a);
      if (q >= (192'sd1 <<< 40)) begin
        res = neg ? -192'sd2147483648 : 192'sd2147483647;
      end else begin
        res = pi[i] + (neg ? -q : q);
        if (res > 192'sd2147483647) res = 192'sd2147483647;
        if (res < -192'sd2147483648) res = -192'sd2147483648;
      end
      o.pt[i] = res[31:0];
    end
    return o;
  endfunction

  function automatic query_t mkq(int px, int py, int pz, int qx, int qy, int qz,
                                 int cx, int cy, int cz, int r, int e, int ix);
    query_t t;
    t.p = {pz, py, px};
    t.q = {qz, qy, qx};
    t.ctr = {cz, cy, cx};
    t.r = r[30:0];
    t.ent = e[0];
    t.idx = ix[0];
    return t;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  task automatic send(query_t it, hit_t want, bit quiet);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    {first_z, first_y, first_x}    <= it.p;
    {second_z, second_y, second_x} <= it.q;
    {center_z, center_y, center_x} <= it.ctr;
    radius         <= it.r;
    enters_first   <= it.ent;
    crossing_index <= it.idx;
    in_valid       <= 1'b1;
    do @(posedge clk); while (!in_ready);
    hits_pending.insert(hits_pending.size(), want);
    n_sent++;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    hit_t e;
    if (!rst && out_valid && out_ready) begin
      if (hits_pending.size() == 0) begin
        report("unexpected transfer", point_x, '0);
      end else begin
        e = hits_pending.pop_front();
        if (point_x !== e.pt[0]) report("point_x", point_x, e.pt[0]);
        if (point_y !== e.pt[1]) report("point_y", point_y, e.pt[1]);
        if (point_z !== e.pt[2]) report("point_z", point_z, e.pt[2]);
        if (status !== e.st) report("status", {30'd0, status}, {30'd0, e.st});
      end
    end
  end

  // receiver: random hold-off per result, one long stall to back up the pipe
  initial begin
    int k, got;
    got = 0;
    @(negedge rst);
    forever begin
      if (got == 300) k = 600;
      else if ((got / 150) % 3 == 2) k = 0;
      else k = $urandom_range(0, 17);
      if (k > 0) begin
        out_ready <= 1'b0;
        repeat (k) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      got++;
    end
  end

  initial begin
    query_t dir_q[N_DIR];
    hit_t   dir_h[N_DIR];
    bit     dir_typed[N_DIR];
    query_t it;
    hit_t   zero_hit;
    int     m;
    logic [31:0] c0, c1, c2, o0, o1, o2;

    zero_hit = '0;
    dir_q[0]  = mkq(ONE, 2*ONE, 3*ONE, ONE, 2*ONE, 3*ONE, 0, 0, 0, ONE, 1, 0);
    dir_q[1]  = mkq(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                    32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 0, 1);
    dir_q[2]  = mkq(-2*ONE, 0, 0, 2*ONE, 0, 0, 0, 0, 0, ONE, 0, 1);
    dir_q[3]  = mkq(-2*ONE, 0, 0, 2*ONE, 0, 0, 0, 0, 0, ONE, 1, 0);
    dir_q[4]  = mkq(-2*ONE, 0, 0, 2*ONE, 0, 0, 0, 0, 0, ONE, 1, 1);
    dir_q[5]  = mkq(-2*ONE, 0, 0, 2*ONE, 0, 0, 0, 0, 0, ONE, 0, 0);
    dir_q[6]  = mkq(-2*ONE, ONE, 0, 2*ONE, ONE, 0, 0, 0, 0, ONE, 1, 0);
    dir_q[7]  = mkq(-2*ONE, 3*ONE, 0, 2*ONE, 3*ONE, 0, 0, 0, 0, 0, 0, 1);
    dir_q[8]  = mkq(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                    32'h7fffffff, 0, 0, 0, 32'h7fffffff, 1, 0);
    dir_q[9]  = mkq(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
                    32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 0, 0);
    dir_q[10] = mkq(0, 0, 0, 1, 1, 1, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 1, 1);
    dir_q[11] = mkq(0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 1, 0);
    dir_q[12] = mkq(0, 0, 0, 1, 0, 0, 0, 0, 0, 32'h7fffffff, 1, 1);
    dir_q[13] = mkq(-1, -1, -1, 0, 0, 0, -1, -1, -1, 1, 1, 0);
    for (int i = 0; i < N_DIR; i++) begin
      dir_typed[i] = (i < 3);
      dir_h[i] = predict_hit(dir_q[i]);
    end
    dir_h[0].pt = dir_q[0].p; dir_h[0].st = ST_ZERO;
    dir_h[1].pt = dir_q[1].p; dir_h[1].st = ST_ZERO;
    dir_h[2] = zero_hit;      dir_h[2].st = ST_BADIDX;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_DIR; i++)
      send(dir_q[i], dir_typed[i] ? dir_h[i] : predict_hit(dir_q[i]), 1'b0);

    for (int i = 0; i < N_RAND; i++) begin
      m = $urandom_range(0, 9);
      c0 = $urandom; c1 = $urandom; c2 = $urandom;
      if (m < 7) begin
        c0 = $signed(c0) >>> 11; c1 = $signed(c1) >>> 11; c2 = $signed(c2) >>> 11;
        o0 = $signed($urandom) >>> 8; o1 = $signed($urandom) >>> 8;
        o2 = $signed($urandom) >>> 8;
        it.ctr = {c2, c1, c0};
        it.p = {c2 + o2, c1 + o1, c0 + o0};
        it.q = {c2 - o2 + ($signed($urandom) >>> 12), c1 - o1 + ($signed($urandom) >>> 12),
                c0 - o0 + ($signed($urandom) >>> 12)};
        it.r = 31'(($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 32'h01ffffff));
      end else begin
        it.ctr = {c2, c1, c0};
        it.p = {$urandom, $urandom, $urandom};
        it.q = (m == 9) ? it.p : {$urandom, $urandom, $urandom};
        it.r = 31'($urandom);
      end
      it.ent = 1'($urandom_range(0, 1));
      it.idx = 1'($urandom_range(0, 1));
      send(it, predict_hit(it), (i / 100) % 4 == 3);
    end
    in_valid <= 1'b0;

    while (hits_pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 50) @(posedge clk);
    if (errors == 0 && hits_pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
